@@ src/preemptive_priority_scheduler_defines.svh @@
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define PPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_UPD,
    ST_CLOSE,
    ST_CALC_TAT,
    ST_CALC_WAIT,
    ST_FIN
  } state_t;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  localparam logic REG_TASK_COUNT = 1'b0;
  localparam logic [4:0] TASK_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic        all_done;
    logic [15:0] response_span;
    logic [15:0] waiting_span;
    logic [15:0] turnaround;
    logic [15:0] completion_at;
    logic [15:0] seg_length;
    logic [3:0]  seg_slot;
    logic [3:0]  running_slot;
    logic [15:0] now_time;
    logic        finished;
    logic        seg_closed;
    logic        busy_res;
  } res_t;

endpackage

`default_nettype wire

@@ src/preemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Preemptive priority scheduler.
// Requests arrive on the s_ channel: s_tuser carries the action (load, tick,
// flush) and s_tdata the load fields. Every request yields exactly one result
// on the m_ channel. The task_count register sits at APB byte address 0.
// A load writes one task table entry in ST_LOAD and passes to ST_FIN. A tick
// scans the table one entry per cycle through the single read port of the
// table memory and one shared compare unit, then passes through ST_CLOSE when
// the scan finds nothing, through ST_UPD when the chosen task keeps running,
// and through ST_UPD, ST_CALC_TAT and ST_CALC_WAIT when that task finishes,
// where the time arithmetic is done. A flush passes through ST_CLOSE. Each
// result is loaded into the output register from ST_FIN. Only one request is
// in flight: s_tready is high again once the result sits in the output
// register, so no new request is taken before the last one's result is there.
// Reset clears all table valid bits, the clock, the open segment and the
// finish count, and sets task_count to 16. If the receiver stalls, the result
// waits in the output register and the next request is still taken; its own
// result waits until the previous one has gone.
module preemptive_priority_scheduler #(
  parameter int MAX_TASKS  = 16,
  parameter int TIME_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // slot[3:0], arrival[19:4], burst[35:20], prio_level[43:36], zero fill
  input  wire logic [47:0] s_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_tuser,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // now_time[15:0], running_slot[19:16], seg_slot[23:20], seg_length[39:24],
  // completion_at[55:40], turnaround[71:56], waiting_span[87:72],
  // response_span[103:88], all_done[104], zero fill
  output      logic [111:0] m_tdata,
  // busy_res[0], seg_closed[1], finished[2]
  output      logic [2:0]  m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  `include "preemptive_priority_scheduler_defines.svh"

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = IW + 1;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  typedef struct packed {
    logic [TIME_WIDTH-1:0] arrival;
    logic [TIME_WIDTH-1:0] burst;
    logic [TIME_WIDTH-1:0] remaining;
    logic [TIME_WIDTH-1:0] first_start;
    logic [7:0]            prio;
    logic                  started;
  } entry_t;

  pps_pkg::state_t state, state_next;

  // Task table memory and its valid bits.
  entry_t               mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] valid_bits;
  logic                 mem_we;
  logic [IW-1:0]        wr_addr;
  entry_t               wr_data;
  logic                 rd_issue;
  entry_t               rd_data;
  logic                 rd_vld;
  logic                 rd_ent_valid;
  logic [IW-1:0]        rd_idx;

  // Latched request.
  logic [1:0]  act;
  logic [3:0]  slot_q;
  logic [15:0] arrival_q;
  logic [15:0] burst_q;
  logic [7:0]  prio_q;

  // Scheduler state.
  logic [TIME_WIDTH-1:0] cur_tick;
  logic                  runner_active;
  logic [IW-1:0]         last_runner;
  logic [TIME_WIDTH-1:0] seg_start;
  logic [4:0]            done_count;
  logic [4:0]            task_count;

  // Scan and update working registers.
  logic [CW-1:0]         scan_cnt;
  logic                  sel_found;
  logic [IW-1:0]         sel_idx;
  entry_t                sel_ent;
  logic [TIME_WIDTH-1:0] tat;
  pps_pkg::res_t         res;
  pps_pkg::res_t         fin_res;
  pps_pkg::res_t         m_res;

  logic                  eligible;
  logic                  better;
  logic                  switch_runner;
  logic                  sel_finishes;
  logic [TIME_WIDTH-1:0] tick_inc;
  logic                  slot_ok;
  entry_t                upd_ent;
  logic                  cfg_we;
  logic                  out_free;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready && (paddr[2] == pps_pkg::REG_TASK_COUNT);
  assign prdata   = (paddr[2] == pps_pkg::REG_TASK_COUNT) ? {27'd0, task_count} : 32'd0;
  assign out_free = !m_tvalid || m_tready;

  assign m_tdata = {7'd0, m_res.all_done, m_res.response_span, m_res.waiting_span,
                    m_res.turnaround, m_res.completion_at, m_res.seg_length,
                    m_res.seg_slot, m_res.running_slot, m_res.now_time};
  assign m_tuser = {m_res.finished, m_res.seg_closed, m_res.busy_res};

  // Shared compare unit of the scan.
  assign eligible = rd_vld && rd_ent_valid && (rd_data.remaining != '0) &&
                    (rd_data.arrival <= cur_tick);
  assign better   = !sel_found || (rd_data.prio < sel_ent.prio) ||
                    ((rd_data.prio == sel_ent.prio) && (rd_data.arrival < sel_ent.arrival));

  assign switch_runner = !runner_active || (last_runner != sel_idx);
  assign sel_finishes  = (sel_ent.remaining == TIME_WIDTH'(1));
  assign tick_inc      = (cur_tick != TIME_MAX) ? cur_tick + TIME_WIDTH'(1) : cur_tick;
  assign slot_ok       = ({28'd0, slot_q} < 32'(MAX_TASKS));

  always_comb begin
    upd_ent           = sel_ent;
    upd_ent.remaining = sel_ent.remaining - TIME_WIDTH'(1);
    if (switch_runner && !sel_ent.started) begin
      upd_ent.started     = 1'b1;
      upd_ent.first_start = cur_tick;
    end
  end

  always_comb begin
    fin_res          = res;
    fin_res.now_time = 16'(cur_tick);
    fin_res.all_done = (done_count >= task_count);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            pps_pkg::ACT_LOAD:  state_next = pps_pkg::ST_LOAD;
            pps_pkg::ACT_TICK:  state_next = pps_pkg::ST_SCAN;
            pps_pkg::ACT_FLUSH: state_next = pps_pkg::ST_CLOSE;
            default:            state_next = pps_pkg::ST_FIN;
          endcase
        end
      end
      pps_pkg::ST_LOAD:  state_next = pps_pkg::ST_FIN;
      pps_pkg::ST_SCAN: begin
        if (scan_cnt == CW'(MAX_TASKS)) begin
          // The last entry is compared in this cycle, so decide on the merged result.
          if (sel_found || eligible) begin
            state_next = pps_pkg::ST_UPD;
          end else begin
            state_next = pps_pkg::ST_CLOSE;
          end
        end
      end
      pps_pkg::ST_UPD: begin
        state_next = sel_finishes ? pps_pkg::ST_CALC_TAT : pps_pkg::ST_FIN;
      end
      pps_pkg::ST_CLOSE:     state_next = pps_pkg::ST_FIN;
      pps_pkg::ST_CALC_TAT:  state_next = pps_pkg::ST_CALC_WAIT;
      pps_pkg::ST_CALC_WAIT: state_next = pps_pkg::ST_FIN;
      pps_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = pps_pkg::ST_IDLE;
        end
      end
      default: state_next = pps_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_tready = 1'b0;
    mem_we   = 1'b0;
    wr_addr  = sel_idx;
    wr_data  = upd_ent;
    rd_issue = 1'b0;
    unique case (state)
      pps_pkg::ST_IDLE: s_tready = 1'b1;
      pps_pkg::ST_LOAD: begin
        mem_we              = slot_ok;
        wr_addr             = IW'(slot_q);
        wr_data.arrival     = TIME_WIDTH'(arrival_q);
        wr_data.burst       = TIME_WIDTH'(burst_q);
        wr_data.remaining   = TIME_WIDTH'(burst_q);
        wr_data.first_start = '0;
        wr_data.prio        = prio_q;
        wr_data.started     = 1'b0;
      end
      pps_pkg::ST_SCAN: rd_issue = (scan_cnt < CW'(MAX_TASKS));
      pps_pkg::ST_UPD:  mem_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rd_data      <= mem[scan_cnt[IW-1:0]];
      rd_ent_valid <= valid_bits[scan_cnt[IW-1:0]];
      rd_idx       <= scan_cnt[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= pps_pkg::TASK_COUNT_RESET;
    end else if (cfg_we) begin
      task_count <= pwdata[4:0];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits    <= '0;
      cur_tick      <= '0;
      runner_active <= 1'b0;
      last_runner   <= '0;
      seg_start     <= '0;
      done_count    <= '0;
      m_tvalid      <= 1'b0;
      rd_vld        <= 1'b0;
      sel_found     <= 1'b0;
      scan_cnt      <= '0;
    end else begin
      if ((state == pps_pkg::ST_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        pps_pkg::ST_IDLE: begin
          rd_vld    <= 1'b0;
          sel_found <= 1'b0;
          scan_cnt  <= '0;
        end
        pps_pkg::ST_LOAD: begin
          if (slot_ok) begin
            valid_bits[IW'(slot_q)] <= 1'b1;
          end
        end
        pps_pkg::ST_SCAN: begin
          rd_vld <= rd_issue;
          if (rd_issue) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          if (eligible && better) begin
            sel_found <= 1'b1;
          end
        end
        pps_pkg::ST_UPD: begin
          if (switch_runner) begin
            seg_start     <= cur_tick;
            runner_active <= 1'b1;
            last_runner   <= sel_idx;
          end
          cur_tick <= tick_inc;
          if (sel_finishes && (done_count != 5'd31)) begin
            done_count <= done_count + 5'd1;
          end
        end
        pps_pkg::ST_CLOSE: begin
          runner_active <= 1'b0;
          seg_start     <= cur_tick;
          if (act == pps_pkg::ACT_TICK) begin
            cur_tick <= tick_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      pps_pkg::ST_IDLE: begin
        act       <= s_tuser;
        slot_q    <= s_tdata[3:0];
        arrival_q <= s_tdata[19:4];
        burst_q   <= s_tdata[35:20];
        prio_q    <= s_tdata[43:36];
        res       <= '0;
      end
      pps_pkg::ST_SCAN: begin
        if (eligible && better) begin
          sel_ent <= rd_data;
          sel_idx <= rd_idx;
        end
      end
      pps_pkg::ST_UPD: begin
        if (switch_runner && runner_active) begin
          res.seg_closed <= 1'b1;
          res.seg_slot   <= 4'(last_runner);
          res.seg_length <= 16'(cur_tick - seg_start);
        end
        sel_ent          <= upd_ent;
        res.busy_res     <= 1'b1;
        res.running_slot <= 4'(sel_idx);
        res.finished     <= sel_finishes;
      end
      pps_pkg::ST_CLOSE: begin
        if (runner_active) begin
          res.seg_closed <= 1'b1;
          res.seg_slot   <= 4'(last_runner);
          res.seg_length <= 16'(cur_tick - seg_start);
        end
      end
      pps_pkg::ST_CALC_TAT: begin
        tat                <= cur_tick - sel_ent.arrival;
        res.completion_at  <= 16'(cur_tick);
        res.turnaround     <= 16'(cur_tick - sel_ent.arrival);
        res.response_span  <= 16'(sel_ent.first_start - sel_ent.arrival);
      end
      pps_pkg::ST_CALC_WAIT: begin
        // At the saturated clock the turnaround can fall below the burst.
        res.waiting_span <= (tat >= sel_ent.burst) ? 16'(tat - sel_ent.burst) : 16'd0;
      end
      pps_pkg::ST_FIN: begin
        if (out_free) begin
          m_res <= fin_res;
        end
      end
      default: begin
      end
    endcase
  end

  `PPS_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken while busy")
  `PPS_ASSERT_NOW(a_upd_has_sel, state == pps_pkg::ST_UPD, sel_found, "update with no task chosen")
  `PPS_ASSERT_NEXT(a_done_monotonic, 1'b1, done_count >= $past(done_count), "finish count fell")
  `PPS_ASSERT_NOW(a_result_from_fin, $rose(m_tvalid), $past(state) == pps_pkg::ST_FIN, "result outside finish")

endmodule

`default_nettype wire
